// ===== sv/hrg_pkg.sv =====
// ----------------------------------------------------------------------------
// hrg_pkg
// Shared types and codes of the horizon region grower.
// ----------------------------------------------------------------------------
package hrg_pkg;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_TRACK = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DROPPED = 2'd1,
		ST_NO_SEED = 2'd2
	} status_t;

	localparam logic [0:0] REG_VWIN  = 1'b0;
	localparam logic [0:0] REG_PLIM  = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_SEED,
		S_SEED_WR,
		S_PEND,
		S_COL,
		S_COL_CHK,
		S_SCAN,
		S_SCAN_LAST,
		S_ADD,
		S_ADD_CHK,
		S_RM,
		S_RM_CHK,
		S_PASS_END,
		S_DONE
	} state_t;

endpackage

// ===== sv/hrg_surface_mem.sv =====
// ----------------------------------------------------------------------------
// hrg_surface_mem
// Column store of the surface: present, expanded and pending flags with level
// and amplitude, one read port and one write port, registered read data.
// ----------------------------------------------------------------------------
module hrg_surface_mem #(
	parameter int AW = 12,
	parameter int LW = 8
) (
	input  logic          clk,
	input  logic [AW-1:0] raddr,
	output logic [LW+34:0] rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [LW+34:0] wdata
);

	logic [LW+34:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/hrg_cand_mem.sv =====
// ----------------------------------------------------------------------------
// hrg_cand_mem
// Candidate store: column, level and amplitude of each loaded candidate.
// ----------------------------------------------------------------------------
module hrg_cand_mem #(
	parameter int AW = 12,
	parameter int DW = 52
) (
	input  logic          clk,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/horizon_region_grower.sv =====
// ----------------------------------------------------------------------------
// horizon_region_grower
// Grows one surface of grid columns from loaded candidate points.
// ----------------------------------------------------------------------------
// A load word is answered the cycle after it is accepted, a read word after
// the column is read and the state passes through S_DONE, and a clear word
// the cycle after; the clear then sweeps the column store, one column
// address per cycle (4096 at the default grid), during which no word is
// accepted. The same sweep runs after reset. A track word runs a sequencer
// over two memories with one read and one write port each: it sweeps the
// column store to clear it, seeds the surface, and then runs passes. Each
// pass latches the pending set in one sweep of the column store, visits
// every column through S_COL and S_COL_CHK, scans the whole candidate store
// for each pending column (one candidate a cycle) to find the best candidate
// for each of the eight neighbors, writes the additions through S_ADD and
// S_ADD_CHK, and finally compacts the candidate store through S_RM and
// S_RM_CHK. Only one word is in flight at a time; input is held off while
// an answer waits.
module horizon_region_grower #(
	parameter int GRID_X         = 64,
	parameter int GRID_Y         = 64,
	parameter int GRID_Z         = 256,
	parameter int MAX_CANDIDATES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[1:0], col_x[7:2], col_y[13:8], level[21:14], amplitude[53:22]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], point_count[14:2], present[15], found_level[23:16],
	// found_amplitude[55:24]
	output logic [55:0] m_tdata
);

	localparam int XW  = (GRID_X > 1) ? $clog2(GRID_X) : 1;
	localparam int YW  = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
	localparam int CAW = XW + YW;
	localparam int LW  = 8;
	localparam int KAW = $clog2(MAX_CANDIDATES);
	localparam int KCW = KAW + 1;
	localparam int CDW = 6 + 6 + LW + 32;
	localparam int SDW = LW + 35;
	localparam logic [CAW-1:0] LAST_COL = '1;

	hrg_pkg::state_t st_q, st_d;

	logic [7:0] vwin_q, plim_q, pass_q;
	logic [KCW-1:0] ccount_q, rd_q, wr_q;
	logic [12:0] ssize_q, orig_q;
	logic [CAW-1:0] col_q;
	logic [5:0] ix_q, iy_q;
	logic [7:0] il_q;
	logic [31:0] ia_q;
	logic out_v_q;
	logic [55:0] out_q;
	logic [3:0] k_q;
	logic [3:0] k_sel;
	logic [8:0] has_q;
	logic [LW-1:0]  bl_q [9];
	logic [31:0]    ba_q [9];
	logic [5:0]     bx_q [9], by_q [9];
	logic [LW-1:0] clvl_q;
	logic clr_busy_q;
	logic pend_v_q, pend_l_q;
	logic [CAW-1:0] pend_a_q;

	logic [CAW-1:0] s_raddr, s_waddr;
	logic [SDW-1:0] s_rdata, s_wdata;
	logic s_we;
	logic [KAW-1:0] c_raddr, c_waddr;
	logic [CDW-1:0] c_rdata, c_wdata;
	logic c_we;

	hrg_surface_mem #(.AW(CAW), .LW(LW)) u_surf (
		.clk(clk), .raddr(s_raddr), .rdata(s_rdata),
		.we(s_we), .waddr(s_waddr), .wdata(s_wdata)
	);

	hrg_cand_mem #(.AW(KAW), .DW(CDW)) u_cand (
		.clk(clk), .raddr(c_raddr), .rdata(c_rdata),
		.we(c_we), .waddr(c_waddr), .wdata(c_wdata)
	);

	// Surface word: {pending, expanded, present, level, amplitude}
	logic s_pres, s_exp, s_pend;
	logic [LW-1:0] s_lvl;
	logic [31:0] s_amp;
	assign s_amp  = s_rdata[31:0];
	assign s_lvl  = s_rdata[LW+31:32];
	assign s_pres = s_rdata[LW+32];
	assign s_exp  = s_rdata[LW+33];
	assign s_pend = s_rdata[LW+34];

	logic [5:0] c_x, c_y;
	logic [LW-1:0] c_l;
	logic [31:0] c_a;
	assign c_a = c_rdata[31:0];
	assign c_l = c_rdata[LW+31:32];
	assign c_y = c_rdata[LW+37:LW+32];
	assign c_x = c_rdata[LW+43:LW+38];

	function automatic logic [CAW-1:0] cidx(input logic [5:0] x, input logic [5:0] y);
		logic [CAW-1:0] r;
		r = CAW'({x[XW-1:0], y[YW-1:0]});
		return r;
	endfunction

	assign k_sel = (k_q > 4'd8) ? 4'd0 : k_q;

	// Neighbor classification of the candidate being scanned.
	logic [XW-1:0] cx;
	logic [YW-1:0] cy;
	logic signed [XW+1:0] dx;
	logic signed [YW+1:0] dy;
	logic [8:0] dl_abs;
	logic nb_ok;
	logic [3:0] nb_k;
	always_comb begin
		cx = col_q[CAW-1:YW];
		cy = col_q[YW-1:0];
		dx = $signed({2'b00, c_x[XW-1:0]}) - $signed({2'b00, cx});
		dy = $signed({2'b00, c_y[YW-1:0]}) - $signed({2'b00, cy});
		dl_abs = (c_l >= clvl_q) ? {1'b0, c_l - clvl_q} : {1'b0, clvl_q - c_l};
		nb_ok = (dx >= -1) && (dx <= 1) && (dy >= -1) && (dy <= 1)
			&& !(dx == 0 && dy == 0) && (dl_abs <= {1'b0, vwin_q});
		nb_k = 4'((dx + 1) * 3 + (dy + 1));
	end

	logic in_acc;
	assign s_tready = (st_q == hrg_pkg::S_IDLE) && !out_v_q && !clr_busy_q;
	assign in_acc = s_tvalid && s_tready;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	logic scan_valid_q;
	logic [KCW-1:0] scan_i_q;

	logic rm_hold_q;
	logic [CDW-1:0] rm_data_q;

	// Compaction write: keep the candidate read at rd_q into slot wr_q.
	logic rm_keep;
	assign rm_keep = (st_q == hrg_pkg::S_RM_CHK) && rm_hold_q
		&& !(s_pres && s_lvl == rm_data_q[LW+31:32]);

	always_comb begin
		st_d = st_q;
		s_raddr = col_q;
		s_we = 1'b0;
		s_waddr = col_q;
		s_wdata = s_rdata;
		c_raddr = rd_q[KAW-1:0];
		c_we = 1'b0;
		c_waddr = wr_q[KAW-1:0];
		c_wdata = c_rdata;
		unique case (st_q)
			hrg_pkg::S_IDLE: begin
				if (in_acc && s_tdata[1:0] == hrg_pkg::OP_LOAD) begin
					c_we = (ccount_q < KCW'(MAX_CANDIDATES)) && s_tdata[21:14] < 9'(GRID_Z)
						&& s_tdata[7:2] < 7'(GRID_X) && s_tdata[13:8] < 7'(GRID_Y);
					c_waddr = ccount_q[KAW-1:0];
					c_wdata = {s_tdata[7:2], s_tdata[13:8], s_tdata[21:14], s_tdata[53:22]};
				end
				s_raddr = cidx(s_tdata[7:2], s_tdata[13:8]);
				c_raddr = '0;
			end
			hrg_pkg::S_CLR: begin
				s_we = 1'b1;
				s_wdata = '0;
			end
			hrg_pkg::S_SEED: c_raddr = '0;
			hrg_pkg::S_SEED_WR: begin
				s_we = 1'b1;
				s_waddr = cidx(c_x, c_y);
				s_wdata = {3'b001, c_l, c_a};
			end
			hrg_pkg::S_PEND: begin
				s_we = pend_v_q;
				s_waddr = pend_a_q;
				s_wdata = s_rdata;
				s_wdata[LW+34] = s_pres && !s_exp;
				s_raddr = col_q;
			end
			hrg_pkg::S_COL: s_raddr = col_q;
			hrg_pkg::S_COL_CHK: c_raddr = '0;
			hrg_pkg::S_SCAN, hrg_pkg::S_SCAN_LAST: c_raddr = rd_q[KAW-1:0];
			hrg_pkg::S_ADD: s_raddr = cidx(bx_q[k_sel], by_q[k_sel]);
			hrg_pkg::S_ADD_CHK: begin
				s_waddr = cidx(bx_q[k_sel], by_q[k_sel]);
				s_we = !s_pres;
				s_wdata = {3'b001, bl_q[k_sel], ba_q[k_sel]};
				if (k_q == 4'd9) begin
					s_waddr = col_q;
					s_we = 1'b1;
					s_wdata = {2'b01, 1'b1, clvl_q, ia_q};
				end
			end
			hrg_pkg::S_RM: begin
				c_raddr = rd_q[KAW-1:0];
			end
			hrg_pkg::S_RM_CHK: begin
				s_raddr = cidx(c_x, c_y);
				c_we = rm_keep;
				c_waddr = wr_q[KAW-1:0];
				c_wdata = rm_data_q;
			end
			default: ;
		endcase
		if (st_q == hrg_pkg::S_RM_CHK) begin
			c_raddr = rd_q[KAW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= hrg_pkg::S_CLR;
			vwin_q <= 8'd1;
			plim_q <= 8'd100;
			pass_q <= '0;
			ccount_q <= '0;
			ssize_q <= '0;
			col_q <= '0;
			out_v_q <= 1'b0;
			clr_busy_q <= 1'b1;
			pend_v_q <= 1'b0;
			pend_l_q <= 1'b0;
			pend_a_q <= '0;
			has_q <= '0;
			k_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			rm_hold_q <= 1'b0;
			scan_valid_q <= 1'b0;
			scan_i_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == hrg_pkg::REG_VWIN) vwin_q <= cfg_wdata;
				else plim_q <= cfg_wdata;
			end
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			unique case (st_q)
				hrg_pkg::S_IDLE: begin
					if (in_acc) begin
						ix_q <= s_tdata[7:2];
						iy_q <= s_tdata[13:8];
						unique case (s_tdata[1:0])
							hrg_pkg::OP_LOAD: begin
								out_v_q <= 1'b1;
								if (c_we) begin
									ccount_q <= ccount_q + 1'b1;
									out_q <= {41'd0, 13'(ccount_q + 1'b1), hrg_pkg::ST_OK};
								end else begin
									out_q <= {41'd0, 13'(ccount_q), hrg_pkg::ST_DROPPED};
								end
							end
							hrg_pkg::OP_TRACK: begin
								if (ccount_q == '0) begin
									out_v_q <= 1'b1;
									out_q <= {41'd0, ssize_q, hrg_pkg::ST_NO_SEED};
								end else begin
									col_q <= '0;
									st_q <= hrg_pkg::S_CLR;
								end
							end
							hrg_pkg::OP_READ: begin
								st_q <= hrg_pkg::S_DONE;
							end
							default: begin
								ccount_q <= '0;
								ssize_q <= '0;
								pass_q <= '0;
								col_q <= '0;
								clr_busy_q <= 1'b1;
								st_q <= hrg_pkg::S_CLR;
								out_v_q <= 1'b1;
								out_q <= '0;
							end
						endcase
					end
				end
				hrg_pkg::S_CLR: begin
					if (col_q == LAST_COL) begin
						col_q <= '0;
						if (clr_busy_q) begin
							clr_busy_q <= 1'b0;
							st_q <= hrg_pkg::S_IDLE;
						end else begin
							st_q <= hrg_pkg::S_SEED;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				hrg_pkg::S_SEED: st_q <= hrg_pkg::S_SEED_WR;
				hrg_pkg::S_SEED_WR: begin
					ssize_q <= 13'd1;
					pass_q <= '0;
					col_q <= '0;
					pend_v_q <= 1'b0;
					pend_l_q <= 1'b0;
					st_q <= hrg_pkg::S_PEND;
				end
				hrg_pkg::S_PEND: begin
					// The word of pend_a_q arrives while col_q is being read.
					if (pend_l_q) begin
						pend_v_q <= 1'b0;
						pend_l_q <= 1'b0;
						orig_q <= ssize_q;
						col_q <= '0;
						st_q <= hrg_pkg::S_COL;
					end else begin
						pend_a_q <= col_q;
						pend_v_q <= 1'b1;
						if (col_q == LAST_COL) pend_l_q <= 1'b1;
						else col_q <= col_q + 1'b1;
					end
				end
				hrg_pkg::S_COL: st_q <= hrg_pkg::S_COL_CHK;
				hrg_pkg::S_COL_CHK: begin
					if (s_pend) begin
						clvl_q <= s_lvl;
						ia_q <= s_amp;
						has_q <= '0;
						rd_q <= KCW'(1);
						scan_i_q <= '0;
						scan_valid_q <= (ccount_q != '0);
						st_q <= hrg_pkg::S_SCAN;
					end else if (col_q == LAST_COL) begin
						rd_q <= '0;
						wr_q <= '0;
						rm_hold_q <= 1'b0;
						st_q <= hrg_pkg::S_RM;
					end else begin
						col_q <= col_q + 1'b1;
						st_q <= hrg_pkg::S_COL;
					end
				end
				hrg_pkg::S_SCAN, hrg_pkg::S_SCAN_LAST: begin
					if (scan_valid_q && nb_ok &&
						(!has_q[nb_k] || $signed(c_a) < $signed(ba_q[nb_k]))) begin
						has_q[nb_k] <= 1'b1;
						bl_q[nb_k] <= c_l;
						ba_q[nb_k] <= c_a;
						bx_q[nb_k] <= c_x;
						by_q[nb_k] <= c_y;
					end
					scan_i_q <= scan_i_q + 1'b1;
					scan_valid_q <= (scan_i_q + 1'b1) < ccount_q;
					rd_q <= rd_q + 1'b1;
					if (!((scan_i_q + 1'b1) < ccount_q)) begin
						k_q <= '0;
						st_q <= hrg_pkg::S_ADD;
					end
				end
				hrg_pkg::S_ADD: begin
					if (k_q == 4'd9 || has_q[k_sel]) st_q <= hrg_pkg::S_ADD_CHK;
					else k_q <= k_q + 1'b1;
				end
				hrg_pkg::S_ADD_CHK: begin
					if (k_q == 4'd9) begin
						if (col_q == LAST_COL) begin
							rd_q <= '0;
							wr_q <= '0;
							rm_hold_q <= 1'b0;
							st_q <= hrg_pkg::S_RM;
						end else begin
							col_q <= col_q + 1'b1;
							st_q <= hrg_pkg::S_COL;
						end
					end else begin
						if (!s_pres) ssize_q <= ssize_q + 1'b1;
						k_q <= k_q + 1'b1;
						st_q <= hrg_pkg::S_ADD;
					end
				end
				hrg_pkg::S_RM: begin
					if (rd_q >= ccount_q) begin
						ccount_q <= wr_q;
						st_q <= hrg_pkg::S_PASS_END;
					end else begin
						st_q <= hrg_pkg::S_RM_CHK;
						rm_hold_q <= 1'b0;
					end
				end
				hrg_pkg::S_RM_CHK: begin
					if (!rm_hold_q) begin
						rm_hold_q <= 1'b1;
						rm_data_q <= c_rdata;
					end else begin
						if (rm_keep) begin
							wr_q <= wr_q + 1'b1;
						end
						rd_q <= rd_q + 1'b1;
						st_q <= hrg_pkg::S_RM;
					end
				end
				hrg_pkg::S_PASS_END: begin
					if (pass_q == plim_q || ssize_q == orig_q) begin
						if (pass_q != plim_q) pass_q <= pass_q + 1'b1;
						out_v_q <= 1'b1;
						out_q <= {41'd0, ssize_q, hrg_pkg::ST_OK};
						st_q <= hrg_pkg::S_IDLE;
					end else begin
						pass_q <= pass_q + 1'b1;
						col_q <= '0;
						st_q <= hrg_pkg::S_PEND;
					end
				end
				hrg_pkg::S_DONE: begin
					out_v_q <= 1'b1;
					if (s_pres && ix_q < 7'(GRID_X) && iy_q < 7'(GRID_Y))
						out_q <= {s_amp, s_lvl, 1'b1, ssize_q, hrg_pkg::ST_OK};
					else
						out_q <= {41'd0, ssize_q, hrg_pkg::ST_OK};
					st_q <= hrg_pkg::S_IDLE;
				end
				default: st_q <= hrg_pkg::S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) in_acc |=> !s_tready)
		else $error("accepted a word while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		ccount_q <= KCW'(MAX_CANDIDATES))
		else $error("candidate count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !m_tready) |=> $stable(out_q))
		else $error("result changed while stalled");

endmodule
